### rtl/sdp_pkg.sv
// Shared types, constants and the divider step for the stereo reprojection pipeline
`timescale 1ns / 1ps

package sdp_pkg;

   // Match-mode disparity window in 1/16 px: (0.5, 128] px
   localparam int MatchMinDisp = 8;
   localparam int MatchMaxDisp = 2048;

   // Three lanes: X, Y, Z
   localparam int Lanes      = 3;
   localparam int LaneX      = 0;
   localparam int LaneY      = 1;
   localparam int LaneZ      = 2;
   localparam int FrontDepth = 4;
   localparam int DivSteps   = 32;
   localparam int NumW       = 44;  // scaled dividend width
   localparam int DenW       = 16;  // |d + center_offset|

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_SOURCE      = 3'd0,
      CSR_CENTER_OFFS = 3'd1,
      CSR_SCALE_X     = 3'd2,
      CSR_SCALE_Y     = 3'd3,
      CSR_PRINCIPAL_X = 3'd4,
      CSR_PRINCIPAL_Y = 3'd5,
      CSR_FOCAL_X     = 3'd6,
      CSR_MAX_DEPTH   = 3'd7
   } sdp_csr_type;

   // Camera settings seen by the front end
   typedef struct packed {
      logic        source;
      logic [15:0] center_offset;
      logic [31:0] scale_x;
      logic [31:0] scale_y;
      logic [15:0] principal_x;
      logic [15:0] principal_y;
      logic [19:0] focal_x;
   } sdp_cfg_type;

   // Word handed from the front end to the divider
   typedef struct packed {
      logic                             good;
      logic [DenW-1:0]                  den;
      logic [Lanes-1:0]                 neg;
      logic [Lanes-1:0]                 ovf;
      logic [Lanes-1:0][NumW-1:0]       num;
   } sdp_work_type;

   // One stage of the long division; low ends up holding the quotient
   typedef struct packed {
      logic                             good;
      logic [DenW-1:0]                  den;
      logic [Lanes-1:0]                 neg;
      logic [Lanes-1:0]                 ovf;
      logic [Lanes-1:0][DenW-1:0]       rem;
      logic [Lanes-1:0][DivSteps-1:0]   low;
   } sdp_div_stage_type;

   // Restoring division, one quotient bit per lane
   function automatic sdp_div_stage_type sdp_div_step(input sdp_div_stage_type s);
      sdp_div_stage_type r;
      logic [DenW:0]     t;
      r = s;
      for (int i = 0; i < Lanes; i++) begin
         t = {s.rem[i], s.low[i][DivSteps-1]};
         if (t >= {1'b0, s.den}) begin
            r.rem[i] = DenW'(t - {1'b0, s.den});
            r.low[i] = {s.low[i][DivSteps-2:0], 1'b1};
         end else begin
            r.rem[i] = t[DenW-1:0];
            r.low[i] = {s.low[i][DivSteps-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

### rtl/sdp_front.sv
// Front end: disparity, products, magnitudes and scaled dividends
`timescale 1ns / 1ps

module sdp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  sdp_pkg::sdp_cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [15:0]           left_x,
   input  logic [15:0]           left_y,
   input  logic [15:0]           right_x,
   input  logic signed [15:0]    dense_disparity,
   input  logic                  match_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sdp_pkg::sdp_work_type out_work
);

   logic [sdp_pkg::FrontDepth-1:0] v_ff;
   logic [sdp_pkg::FrontDepth-1:0] en;

   // stage 1
   logic                s1_good_ff, s1_good_in;
   logic signed [17:0]  s1_den_ff,  s1_den_in;
   logic signed [16:0]  s1_dx_ff,   s1_dx_in;
   logic signed [16:0]  s1_dy_ff,   s1_dy_in;
   // stage 2
   logic                s2_good_ff;
   logic                s2_dneg_ff;
   logic [15:0]         s2_den_ff,  s2_den_in;
   logic signed [52:0]  s2_prod_ff [sdp_pkg::Lanes];
   logic signed [52:0]  s2_prod_in [sdp_pkg::Lanes];
   // stage 3
   logic                s3_good_ff;
   logic [15:0]         s3_den_ff;
   logic [sdp_pkg::Lanes-1:0] s3_neg_ff, s3_neg_in;
   logic [51:0]         s3_un_ff [sdp_pkg::Lanes];
   logic [51:0]         s3_un_in [sdp_pkg::Lanes];
   // stage 4
   sdp_pkg::sdp_work_type s4_ff, s4_in;

   logic signed [16:0]  dm, dd, d;
   logic                win_ok;
   logic signed [20:0]  mul_a [sdp_pkg::Lanes];
   logic signed [31:0]  mul_b [sdp_pkg::Lanes];
   logic [51:0]         nsum [sdp_pkg::Lanes];

   // stall chain, last stage first
   always_comb begin
      en[3] = !v_ff[3] || out_ready;
      en[2] = !v_ff[2] || en[3];
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[3];
   assign out_work  = s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
      end
   end

   // stage 1: disparity, denominator and offsets from the principal point
   always_comb begin
      dm = $signed({1'b0, left_x}) - $signed({1'b0, right_x});
      dd = dense_disparity[15] ? 17'sd0 : {dense_disparity[15], dense_disparity};
      d  = cfg.source ? dd : dm;
      win_ok = cfg.source ||
               (dm > 17'(sdp_pkg::MatchMinDisp) && dm <= 17'(sdp_pkg::MatchMaxDisp));
      s1_den_in  = {d[16], d} + {{2{cfg.center_offset[15]}}, cfg.center_offset};
      s1_good_in = match_ok && win_ok && (d > 17'sd0) && (s1_den_in != 18'sd0);
      s1_dx_in   = $signed({1'b0, left_x}) - $signed({1'b0, cfg.principal_x});
      s1_dy_in   = $signed({1'b0, left_y}) - $signed({1'b0, cfg.principal_y});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_good_ff <= s1_good_in;
         s1_den_ff  <= s1_den_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
      end
   end

   // stage 2: one 21x32 multiplier per lane
   always_comb begin
      mul_a[sdp_pkg::LaneX] = {{4{s1_dx_ff[16]}}, s1_dx_ff};
      mul_a[sdp_pkg::LaneY] = {{4{s1_dy_ff[16]}}, s1_dy_ff};
      mul_a[sdp_pkg::LaneZ] = $signed({1'b0, cfg.focal_x});
      mul_b[sdp_pkg::LaneX] = $signed(cfg.scale_x);
      mul_b[sdp_pkg::LaneY] = $signed(cfg.scale_y);
      mul_b[sdp_pkg::LaneZ] = $signed(cfg.scale_x);
      for (int i = 0; i < sdp_pkg::Lanes; i++) begin
         s2_prod_in[i] = mul_a[i] * mul_b[i];
      end
      s2_den_in = s1_den_ff[17] ? 16'(-s1_den_ff) : s1_den_ff[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_good_ff <= s1_good_ff;
         s2_dneg_ff <= s1_den_ff[17];
         s2_den_ff  <= s2_den_in;
         for (int i = 0; i < sdp_pkg::Lanes; i++) s2_prod_ff[i] <= s2_prod_in[i];
      end
   end

   // stage 3: magnitudes and quotient signs
   always_comb begin
      for (int i = 0; i < sdp_pkg::Lanes; i++) begin
         s3_un_in[i]  = s2_prod_ff[i][52] ? 52'(-s2_prod_ff[i]) : s2_prod_ff[i][51:0];
         s3_neg_in[i] = s2_prod_ff[i][52] ^ s2_dneg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_good_ff <= s2_good_ff;
         s3_den_ff  <= s2_den_ff;
         s3_neg_ff  <= s3_neg_in;
         for (int i = 0; i < sdp_pkg::Lanes; i++) s3_un_ff[i] <= s3_un_in[i];
      end
   end

   // stage 4: fold rounding and the 256 scale into the dividend, flag overflow
   always_comb begin
      s4_in.good = s3_good_ff;
      s4_in.den  = s3_den_ff;
      s4_in.neg  = s3_neg_ff;
      for (int i = 0; i < sdp_pkg::Lanes; i++) begin
         nsum[i]        = s3_un_ff[i] + {29'd0, s3_den_ff, 7'd0};
         s4_in.num[i]   = nsum[i][51:8];
         s4_in.ovf[i]   = {4'd0, nsum[i][51:8]} >= {s3_den_ff, 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) s4_ff <= s4_in;
   end

endmodule

### rtl/sdp_div.sv
// Pipelined restoring divider, one quotient bit per stage for three lanes
`timescale 1ns / 1ps

module sdp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  sdp_pkg::sdp_work_type      in_work,
   output logic                       out_valid,
   input  logic                       out_ready,
   output sdp_pkg::sdp_div_stage_type out_stage
);

   localparam int N = sdp_pkg::DivSteps;

   logic [N-1:0]               v_ff;
   logic [N-1:0]               en;
   sdp_pkg::sdp_div_stage_type st_ff [N];
   sdp_pkg::sdp_div_stage_type st_in [N];
   sdp_pkg::sdp_div_stage_type head;

   // first partial remainder is the top of the dividend
   always_comb begin
      head.good = in_work.good;
      head.den  = in_work.den;
      head.neg  = in_work.neg;
      head.ovf  = in_work.ovf;
      for (int i = 0; i < sdp_pkg::Lanes; i++) begin
         head.rem[i] = {4'd0, in_work.num[i][sdp_pkg::NumW-1:N]};
         head.low[i] = in_work.num[i][N-1:0];
      end
   end

   // stall chain
   always_comb begin
      en[N-1] = !v_ff[N-1] || out_ready;
      for (int k = N-2; k >= 0; k--) en[k] = !v_ff[k] || en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = v_ff[N-1];
   assign out_stage = st_ff[N-1];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_step
         if (k == 0) begin : g_head
            assign st_in[k] = sdp_pkg::sdp_div_step(head);
            always_ff @(posedge clock) begin
               if (reset) v_ff[k] <= 1'b0;
               else if (en[k]) v_ff[k] <= in_valid;
            end
         end else begin : g_body
            assign st_in[k] = sdp_pkg::sdp_div_step(st_ff[k-1]);
            always_ff @(posedge clock) begin
               if (reset) v_ff[k] <= 1'b0;
               else if (en[k]) v_ff[k] <= v_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en[k]) st_ff[k] <= st_in[k];
         end
      end
   endgenerate

endmodule

### rtl/stereo_disparity_to_point.sv
// Top level: stereo keypoint to 3D point reprojection pipeline
//
//   channel  direction  words carried
//   req_     in         left_x, left_y, right_x, dense_disparity, match_ok
//   rsp_     out        point_x, point_y, point_z, point_valid
//   csr_     in         csr_index, csr_data (register write)
//
// One keypoint per cycle while rsp_ready is high; four front-end stages,
// 32 divider stages (one quotient bit each) and the output register.
// Synchronous active-high reset empties the pipeline and clears the configuration registers.
// A stalled rsp_ holds each stage that is full; empty stages still fill.
// csr_ready is always high.
`timescale 1ns / 1ps

module stereo_disparity_to_point (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_left_x,
   input  logic [15:0]        req_left_y,
   input  logic [15:0]        req_right_x,
   input  logic signed [15:0] req_dense_disparity,
   input  logic               req_match_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic               rsp_point_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic        source_ff;
   logic [15:0] center_offset_ff;
   logic [31:0] scale_x_ff, scale_y_ff;
   logic [15:0] principal_x_ff, principal_y_ff;
   logic [19:0] focal_x_ff;
   logic [30:0] max_depth_ff;

   sdp_pkg::sdp_cfg_type       cfg;
   sdp_pkg::sdp_work_type      work;
   sdp_pkg::sdp_div_stage_type quo;
   logic work_valid, work_ready, quo_valid, quo_ready;

   logic        rsp_valid_ff;
   logic [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_x_in, rsp_y_in, rsp_z_in;
   logic        rsp_pv_ff, rsp_pv_in;
   logic [31:0] sat [sdp_pkg::Lanes];

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff        <= 1'b0;
         center_offset_ff <= '0;
         scale_x_ff       <= '0;
         scale_y_ff       <= '0;
         principal_x_ff   <= '0;
         principal_y_ff   <= '0;
         focal_x_ff       <= '0;
         max_depth_ff     <= '0;
      end else if (csr_valid) begin
         unique case (sdp_pkg::sdp_csr_type'(csr_index))
            sdp_pkg::CSR_SOURCE:      source_ff        <= csr_data[0];
            sdp_pkg::CSR_CENTER_OFFS: center_offset_ff <= csr_data[15:0];
            sdp_pkg::CSR_SCALE_X:     scale_x_ff       <= csr_data;
            sdp_pkg::CSR_SCALE_Y:     scale_y_ff       <= csr_data;
            sdp_pkg::CSR_PRINCIPAL_X: principal_x_ff   <= csr_data[15:0];
            sdp_pkg::CSR_PRINCIPAL_Y: principal_y_ff   <= csr_data[15:0];
            sdp_pkg::CSR_FOCAL_X:     focal_x_ff       <= csr_data[19:0];
            sdp_pkg::CSR_MAX_DEPTH:   max_depth_ff     <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   assign cfg.source        = source_ff;
   assign cfg.center_offset = center_offset_ff;
   assign cfg.scale_x       = scale_x_ff;
   assign cfg.scale_y       = scale_y_ff;
   assign cfg.principal_x   = principal_x_ff;
   assign cfg.principal_y   = principal_y_ff;
   assign cfg.focal_x       = focal_x_ff;

   sdp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .left_x          (req_left_x),
      .left_y          (req_left_y),
      .right_x         (req_right_x),
      .dense_disparity (req_dense_disparity),
      .match_ok        (req_match_ok),
      .out_valid       (work_valid),
      .out_ready       (work_ready),
      .out_work        (work)
   );

   sdp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (work_valid),
      .in_ready  (work_ready),
      .in_work   (work),
      .out_valid (quo_valid),
      .out_ready (quo_ready),
      .out_stage (quo)
   );

   // sign and saturation to signed 32 bits, then the depth checks
   always_comb begin
      for (int i = 0; i < sdp_pkg::Lanes; i++) begin
         if (quo.neg[i]) begin
            sat[i] = (quo.ovf[i] || quo.low[i] > 32'h8000_0000) ? 32'h8000_0000
                                                               : 32'(-quo.low[i]);
         end else begin
            sat[i] = (quo.ovf[i] || quo.low[i][31]) ? 32'h7FFF_FFFF : quo.low[i];
         end
      end
      rsp_pv_in = quo.good && !sat[sdp_pkg::LaneZ][31] &&
                  (sat[sdp_pkg::LaneZ] != 32'd0) &&
                  ((max_depth_ff == 31'd0) ||
                   (sat[sdp_pkg::LaneZ] <= {1'b0, max_depth_ff}));
      rsp_x_in = rsp_pv_in ? sat[sdp_pkg::LaneX] : 32'd0;
      rsp_y_in = rsp_pv_in ? sat[sdp_pkg::LaneY] : 32'd0;
      rsp_z_in = rsp_pv_in ? sat[sdp_pkg::LaneZ] : 32'd0;
   end

   // output register
   assign quo_ready = !rsp_valid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (quo_ready) rsp_valid_ff <= quo_valid;
   end
   always_ff @(posedge clock) begin
      if (quo_ready) begin
         rsp_x_ff  <= rsp_x_in;
         rsp_y_ff  <= rsp_y_in;
         rsp_z_ff  <= rsp_z_in;
         rsp_pv_ff <= rsp_pv_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_z     = rsp_z_ff;
   assign rsp_point_valid = rsp_pv_ff;

   // a rejected point carries zero coordinates
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |->
         rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0 && rsp_point_z == 32'sd0)
      else $error("rejected point with nonzero coordinates");

   // an accepted point lies in front of the camera
   a_z_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid |-> rsp_point_z > 32'sd0)
      else $error("valid point with non-positive depth");

   // depth limit holds when enabled
   a_z_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid && max_depth_ff != 31'd0 |->
         rsp_point_z <= $signed({1'b0, max_depth_ff}))
      else $error("valid point beyond depth limit");

   // reset empties the output
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule
